FILE: rtl/casf_pkg.sv
// shared types, opcodes, microcode program and size helpers for the alu with condition codes
// no dependencies; imported by casf_dp, cpu_alu_shift_flags_top, alu_flag_checker and the testbench
package casf_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 6;
    localparam int STEP_W = 3;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_ADDX = 4'd1,
        OP_SUB  = 4'd2,
        OP_SUBX = 4'd3,
        OP_CMP  = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_EOR  = 4'd7,
        OP_ASL  = 4'd8,
        OP_ASR  = 4'd9,
        OP_LSL  = 4'd10,
        OP_LSR  = 4'd11,
        OP_ROL  = 4'd12,
        OP_ROR  = 4'd13,
        OP_ROXL = 4'd14,
        OP_ROXR = 4'd15
    } alu_op_t;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    // micro-operations executed by the datapath
    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_INIT,
        UOP_SHIFT,
        UOP_ALU,
        UOP_RETIRE
    } uop_t;

    // jump conditions evaluated by the sequencer
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_START,
        COND_NOT_SHIFT,
        COND_CNT_GT1,
        COND_OUT_BUSY
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_LOAD   = 3'd0;
    localparam step_t STEP_INIT   = 3'd1;
    localparam step_t STEP_SHIFT  = 3'd2;
    localparam step_t STEP_HOLD   = 3'd3;
    localparam step_t STEP_RETIRE = 3'd4;
    localparam step_t STEP_ALU    = 3'd5;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t target;
    } ucode_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic is_shift;
        logic cnt_gt1;
    } dp_status_t;

    // control store: jump to target when cond holds, else fall through
    function automatic ucode_t ucode_rom(input step_t addr);
        ucode_t w;
        unique case (addr)
            STEP_LOAD:   w = '{UOP_LOAD,   COND_NO_START,  STEP_LOAD};
            STEP_INIT:   w = '{UOP_INIT,   COND_NOT_SHIFT, STEP_ALU};
            STEP_SHIFT:  w = '{UOP_SHIFT,  COND_CNT_GT1,   STEP_SHIFT};
            STEP_HOLD:   w = '{UOP_NOP,    COND_OUT_BUSY,  STEP_HOLD};
            STEP_RETIRE: w = '{UOP_RETIRE, COND_ALWAYS,    STEP_LOAD};
            STEP_ALU:    w = '{UOP_ALU,    COND_ALWAYS,    STEP_HOLD};
            default:     w = '{UOP_NOP,    COND_ALWAYS,    STEP_LOAD};
        endcase
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
        logic [DATA_W-1:0] m;
        if (size == SIZE_BYTE) m = 32'h0000_00FF;
        else if (size == SIZE_WORD) m = 32'h0000_FFFF;
        else m = 32'hFFFF_FFFF;
        return m;
    endfunction

    function automatic logic top_bit(input logic [DATA_W-1:0] val, input logic [1:0] size);
        logic b;
        if (size == SIZE_BYTE) b = val[7];
        else if (size == SIZE_WORD) b = val[15];
        else b = val[31];
        return b;
    endfunction

endpackage

FILE: rtl/casf_dp.sv
// datapath: operand registers, adder/subtractor, logic unit, one-place shifter, flag state
// depends on casf_pkg; driven one micro-operation per cycle by the sequencer in the top level
module casf_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  casf_pkg::uop_t                    uop,
    input  logic [3:0]                        action,
    input  logic [1:0]                        size,
    input  logic [casf_pkg::DATA_W-1:0]       source,
    input  logic [casf_pkg::DATA_W-1:0]       target,
    input  logic [casf_pkg::CNT_W-1:0]        shift_count,
    output casf_pkg::dp_status_t              status,
    output logic [casf_pkg::DATA_W-1:0]       value,
    output logic                              carry,
    output logic                              overflow,
    output logic                              zero,
    output logic                              negative,
    output logic                              extend_flag
);
    import casf_pkg::*;

    alu_op_t           op_reg;
    logic [1:0]        size_reg;
    logic [DATA_W-1:0] src_reg, src_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              c_reg, c_next;
    logic              v_reg, v_next;
    logic              xn_reg, xn_next;
    logic              ext_reg, ext_next;
    logic              zst_reg, zst_next;

    logic [DATA_W-1:0] value_reg;
    logic              carry_reg, overflow_reg, zero_reg, negative_reg, ext_out_reg;

    logic [DATA_W-1:0] mask, msb;
    logic              is_sub, cin;
    logic [DATA_W:0]   sum, dif, wide;
    logic [DATA_W-1:0] ovf_vec;
    logic              alu_c, alu_v;
    logic [DATA_W-1:0] alu_r;
    logic              tb, left, sh_in, sh_c;
    logic [DATA_W-1:0] sh_r;
    logic              res_z;

    assign mask   = size_mask(size_reg);
    assign msb    = mask ^ (mask >> 1);
    assign is_sub = (op_reg == OP_SUB) || (op_reg == OP_SUBX) || (op_reg == OP_CMP);
    assign cin    = ((op_reg == OP_ADDX) || (op_reg == OP_SUBX)) ? ext_reg : 1'b0;

    // add / subtract with extend, carry taken at the sized top
    assign sum  = {1'b0, r_reg} + {1'b0, src_reg} + {{DATA_W{1'b0}}, cin};
    assign dif  = {1'b0, r_reg} - {1'b0, src_reg} - {{DATA_W{1'b0}}, cin};
    assign wide = is_sub ? dif : sum;

    always_comb
    begin
        if (is_sub) ovf_vec = (r_reg ^ src_reg) & (r_reg ^ wide[DATA_W-1:0]);
        else        ovf_vec = ~(r_reg ^ src_reg) & (r_reg ^ wide[DATA_W-1:0]);

        if (size_reg == SIZE_BYTE) alu_c = wide[8];
        else if (size_reg == SIZE_WORD) alu_c = wide[16];
        else alu_c = wide[DATA_W];

        alu_v = top_bit(ovf_vec, size_reg);

        unique case (op_reg)
            OP_AND:  alu_r = r_reg & src_reg;
            OP_OR:   alu_r = r_reg | src_reg;
            OP_EOR:  alu_r = r_reg ^ src_reg;
            default: alu_r = wide[DATA_W-1:0] & mask;
        endcase
    end

    // one place of shift or rotate
    always_comb
    begin
        tb   = top_bit(r_reg, size_reg);
        left = (op_reg == OP_ASL) || (op_reg == OP_LSL) || (op_reg == OP_ROL)
            || (op_reg == OP_ROXL);
        unique case (op_reg)
            OP_ROL, OP_ASR:   sh_in = tb;
            OP_ROR:           sh_in = r_reg[0];
            OP_ROXL, OP_ROXR: sh_in = c_reg;
            default:          sh_in = 1'b0;
        endcase
        if (left)
        begin
            sh_r = ((r_reg << 1) | {{(DATA_W-1){1'b0}}, sh_in}) & mask;
            sh_c = tb;
        end
        else
        begin
            sh_r = (r_reg >> 1) | (sh_in ? msb : '0);
            sh_c = r_reg[0];
        end
    end

    // extend forms keep the old zero flag on a zero result
    assign res_z = (r_reg != '0) ? 1'b0
                 : (((op_reg == OP_ADDX) || (op_reg == OP_SUBX)) ? zst_reg : 1'b1);

    always_comb
    begin
        src_next = src_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        c_next   = c_reg;
        v_next   = v_reg;
        xn_next  = xn_reg;
        ext_next = ext_reg;
        zst_next = zst_reg;
        unique case (uop)
            UOP_INIT:
            begin
                src_next = src_reg & mask;
                r_next   = r_reg & mask;
                c_next   = ((op_reg == OP_ROXL) || (op_reg == OP_ROXR)) ? ext_reg : 1'b0;
                v_next   = 1'b0;
                xn_next  = ext_reg;
            end
            UOP_SHIFT:
            begin
                if (cnt_reg != '0)
                begin
                    r_next   = sh_r;
                    c_next   = sh_c;
                    cnt_next = cnt_reg - 1'b1;
                    if (op_reg == OP_ASL)
                        v_next = v_reg | (tb ^ top_bit(sh_r, size_reg));
                    if ((op_reg != OP_ROL) && (op_reg != OP_ROR))
                        xn_next = sh_c;
                end
            end
            UOP_ALU:
            begin
                r_next = alu_r;
                if ((op_reg == OP_AND) || (op_reg == OP_OR) || (op_reg == OP_EOR))
                begin
                    c_next = 1'b0;
                    v_next = 1'b0;
                end
                else
                begin
                    c_next = alu_c;
                    v_next = alu_v;
                    if (op_reg != OP_CMP) xn_next = alu_c;
                end
            end
            UOP_RETIRE:
            begin
                ext_next = xn_reg;
                zst_next = res_z;
            end
            default:
            begin
            end
        endcase
    end

    // operand and work registers
    always_ff @(posedge clk)
    begin
        if (uop == UOP_LOAD)
        begin
            op_reg   <= alu_op_t'(action);
            size_reg <= size;
            src_reg  <= source;
            r_reg    <= target;
            cnt_reg  <= shift_count;
        end
        else
        begin
            src_reg <= src_next;
            r_reg   <= r_next;
            cnt_reg <= cnt_next;
        end
        c_reg  <= c_next;
        v_reg  <= v_next;
        xn_reg <= xn_next;
        if (uop == UOP_RETIRE)
        begin
            value_reg    <= r_reg;
            carry_reg    <= c_reg;
            overflow_reg <= v_reg;
            zero_reg     <= res_z;
            negative_reg <= top_bit(r_reg, size_reg);
            ext_out_reg  <= xn_reg;
        end
    end

    // kept condition codes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= 1'b0;
            zst_reg <= 1'b0;
        end
        else
        begin
            ext_reg <= ext_next;
            zst_reg <= zst_next;
        end
    end

    assign status.is_shift = (op_reg == OP_ASL) || (op_reg == OP_ASR) || (op_reg == OP_LSL)
                          || (op_reg == OP_LSR) || (op_reg == OP_ROL) || (op_reg == OP_ROR)
                          || (op_reg == OP_ROXL) || (op_reg == OP_ROXR);
    assign status.cnt_gt1  = (cnt_reg > CNT_W'(1));

    assign value       = value_reg;
    assign carry       = carry_reg;
    assign overflow    = overflow_reg;
    assign zero        = zero_reg;
    assign negative    = negative_reg;
    assign extend_flag = ext_out_reg;

endmodule

FILE: rtl/cpu_alu_shift_flags_top.sv
// top level: microcode sequencer, result handshake and the alu datapath
// depends on casf_pkg and casf_dp
// processor alu with byte, word and long operands that keeps the x and z flags between
// transactions. one input transaction is taken when in_valid and in_ready are high; in_ready
// is high while the sequencer sits at its load step. control is a six-step microprogram held in
// a read-only control store: each step issues one micro-operation to the datapath and may jump
// on a condition. add, addx, sub, subx, cmp, and, or and eor run the load, init, alu, hold and
// retire steps; shifts and rotates run load, init, the shift step once per place (at least
// once), hold, retire; one place is shifted per cycle. the result register holds a finished
// transaction while the next one is accepted and worked on; the sequencer waits at its hold
// step only if that register is still full when the next result is ready. x and z reset to 0.
module cpu_alu_shift_flags_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [3:0]                     action,
    input  logic [1:0]                     size,
    input  logic [casf_pkg::DATA_W-1:0]    source,
    input  logic [casf_pkg::DATA_W-1:0]    target,
    input  logic [casf_pkg::CNT_W-1:0]     shift_count,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [casf_pkg::DATA_W-1:0]    value,
    output logic                           carry,
    output logic                           overflow,
    output logic                           zero,
    output logic                           negative,
    output logic                           extend_flag
);
    import casf_pkg::*;

    step_t      step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    ucode_t     uword;
    logic       taken;
    uop_t       uop;
    dp_status_t status;

    // current control word
    assign uword = ucode_rom(step_reg);

    // jump condition of the current step
    always_comb
    begin
        unique case (uword.cond)
            COND_ALWAYS:    taken = 1'b1;
            COND_NO_START:  taken = !in_valid;
            COND_NOT_SHIFT: taken = !status.is_shift;
            COND_CNT_GT1:   taken = status.cnt_gt1;
            COND_OUT_BUSY:  taken = out_valid_reg && !out_ready;
            default:        taken = 1'b1;
        endcase
        step_next = taken ? uword.target : step_reg + 1'b1;

        // the load step only captures operands on an accepted transaction
        if ((uword.uop == UOP_LOAD) && !in_valid) uop = UOP_NOP;
        else uop = uword.uop;

        // result register fills on retire, empties when taken
        if (uop == UOP_RETIRE) out_valid_next = 1'b1;
        else if (out_ready) out_valid_next = 1'b0;
        else out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (step_reg == STEP_LOAD);
    assign out_valid = out_valid_reg;

    casf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .uop         (uop),
        .action      (action),
        .size        (size),
        .source      (source),
        .target      (target),
        .shift_count (shift_count),
        .status      (status),
        .value       (value),
        .carry       (carry),
        .overflow    (overflow),
        .zero        (zero),
        .negative    (negative),
        .extend_flag (extend_flag)
    );

endmodule

FILE: test/alu_flag_checker.sv
`timescale 1ns / 1ps
// scoreboard for the alu with condition codes: watches both channels, predicts each result
// depends on casf_pkg for the operation and size codes; instantiated by cpu_alu_shift_flags_top_tb
module alu_flag_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [3:0]                  action,
    input  logic [1:0]                  size,
    input  logic [casf_pkg::DATA_W-1:0] source,
    input  logic [casf_pkg::DATA_W-1:0] target,
    input  logic [casf_pkg::CNT_W-1:0]  shift_count,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [casf_pkg::DATA_W-1:0] value,
    input  logic                        carry,
    input  logic                        overflow,
    input  logic                        zero,
    input  logic                        negative,
    input  logic                        extend_flag,
    output int                          errors,
    output int                          outstanding
);

    import casf_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        carry;
        logic        overflow;
        logic        zero;
        logic        negative;
        logic        extend;
    } alu_flags_t;

    alu_flags_t  pending_results[$];
    logic        x_flag;
    logic        z_flag;

    function automatic alu_flags_t predict_alu_flags(
        input alu_op_t     op,
        input logic [1:0]  sz,
        input logic [31:0] src_in,
        input logic [31:0] tgt_in,
        input logic [5:0]  cnt,
        input logic        x_in,
        input logic        z_in
    );
        int          bits;
        int          top;
        int          i;
        logic [31:0] mask;
        logic [31:0] msb;
        logic [31:0] src;
        logic [31:0] tgt;
        logic [31:0] r;
        logic [31:0] prev;
        logic [31:0] ovf;
        logic [63:0] wide;
        logic        c;
        logic        v;
        logic        x;
        logic        e;
        logic        keep_z;
        alu_flags_t  res;
        bits = (sz == SIZE_BYTE) ? 8 : (sz == SIZE_WORD) ? 16 : 32;
        mask = 32'((64'd1 << bits) - 64'd1);
        top = bits - 1;
        msb = 32'd1 << top;
        src = src_in & mask;
        tgt = tgt_in & mask;
        r = 32'd0;
        c = 1'b0;
        v = 1'b0;
        x = x_in;
        keep_z = 1'b0;
        if (op <= OP_CMP)
        begin
            if (op == OP_ADD || op == OP_ADDX)
            begin
                wide = 64'(src) + 64'(tgt) + ((op == OP_ADDX) ? 64'(x_in) : 64'd0);
                ovf = ~(tgt ^ src) & (tgt ^ wide[31:0]);
            end
            else
            begin
                wide = 64'(tgt) - 64'(src) - ((op == OP_SUBX) ? 64'(x_in) : 64'd0);
                ovf = (tgt ^ src) & (tgt ^ wide[31:0]);
            end
            v = ovf[top];
            c = wide[bits];
            r = wide[31:0] & mask;
            if (op != OP_CMP)
                x = c;
            keep_z = (op == OP_ADDX || op == OP_SUBX);
        end
        else if (op <= OP_EOR)
        begin
            if (op == OP_AND)
                r = tgt & src;
            else if (op == OP_OR)
                r = tgt | src;
            else
                r = tgt ^ src;
        end
        else
        begin
            r = tgt;
            if (op == OP_ROXL || op == OP_ROXR)
                c = x_in;
            for (i = 0; i < int'(cnt); i++)
            begin
                prev = r;
                e = c;
                case (op)
                    OP_ASL:
                    begin
                        c = r[top];
                        r = (r << 1) & mask;
                        v = v | (prev[top] ^ r[top]);
                    end
                    OP_ASR:
                    begin
                        c = r[0];
                        r = (r >> 1) | (r & msb);
                    end
                    OP_LSL:
                    begin
                        c = r[top];
                        r = (r << 1) & mask;
                    end
                    OP_LSR:
                    begin
                        c = r[0];
                        r = r >> 1;
                    end
                    OP_ROL:
                    begin
                        c = r[top];
                        r = ((r << 1) | 32'(c)) & mask;
                    end
                    OP_ROR:
                    begin
                        c = r[0];
                        r = (r >> 1) | (c ? msb : 32'd0);
                    end
                    OP_ROXL:
                    begin
                        c = r[top];
                        r = ((r << 1) | 32'(e)) & mask;
                    end
                    default:
                    begin
                        c = r[0];
                        r = (r >> 1) | (e ? msb : 32'd0);
                    end
                endcase
            end
            if (op == OP_ROXL || op == OP_ROXR)
                x = c;
            else if (op <= OP_LSR && cnt != 6'd0)
                x = c;
        end
        r = r & mask;
        res.value = r;
        res.carry = c;
        res.overflow = v;
        res.zero = (r != 32'd0) ? 1'b0 : (keep_z ? z_in : 1'b1);
        res.negative = r[top];
        res.extend = x;
        return res;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        alu_flags_t fresh;
        alu_flags_t want;
        if (!rst_n)
        begin
            x_flag <= 1'b0;
            z_flag <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                fresh = predict_alu_flags(alu_op_t'(action), size, source, target, shift_count,
                                          x_flag, z_flag);
                pending_results.push_back(fresh);
                x_flag <= fresh.extend;
                z_flag <= fresh.zero;
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual value %h",
                             $time, value);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (value !== want.value)
                        report_field("value", want.value, value);
                    if (carry !== want.carry)
                        report_field("carry", 32'(want.carry), 32'(carry));
                    if (overflow !== want.overflow)
                        report_field("overflow", 32'(want.overflow), 32'(overflow));
                    if (zero !== want.zero)
                        report_field("zero", 32'(want.zero), 32'(zero));
                    if (negative !== want.negative)
                        report_field("negative", 32'(want.negative), 32'(negative));
                    if (extend_flag !== want.extend)
                        report_field("extend_flag", 32'(want.extend), 32'(extend_flag));
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

FILE: test/cpu_alu_shift_flags_top_tb.sv
`timescale 1ns / 1ps
// testbench top for the alu with condition codes: clock, reset, stimulus and verdict
// depends on casf_pkg, cpu_alu_shift_flags_top and alu_flag_checker
module cpu_alu_shift_flags_top_tb;

    import casf_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [3:0]          action;
    logic [1:0]          size;
    logic [DATA_W-1:0]   source;
    logic [DATA_W-1:0]   target;
    logic [CNT_W-1:0]    shift_count;
    logic                out_valid;
    logic                out_ready;
    logic [DATA_W-1:0]   value;
    logic                carry;
    logic                overflow;
    logic                zero;
    logic                negative;
    logic                extend_flag;
    int                  errors;
    int                  outstanding;

    // chance in percent that the sender idles / the receiver stalls on a given cycle
    int                  idle_pct;
    int                  stall_pct;

    localparam logic [1:0] SIZE_LONG   = 2'd2;
    localparam logic [1:0] SIZE_SPARE  = 2'd3;  // unused code, behaves as long
    localparam int         PHASE_ITEMS = 113;

    cpu_alu_shift_flags_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .size        (size),
        .source      (source),
        .target      (target),
        .shift_count (shift_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .carry       (carry),
        .overflow    (overflow),
        .zero        (zero),
        .negative    (negative),
        .extend_flag (extend_flag)
    );

    // scoreboard sits beside the block and only watches
    alu_flag_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .size        (size),
        .source      (source),
        .target      (target),
        .shift_count (shift_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .carry       (carry),
        .overflow    (overflow),
        .zero        (zero),
        .negative    (negative),
        .extend_flag (extend_flag),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver side: out_ready is redrawn at every falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // operand values biased toward corners so zero results and carries show up often
    function automatic logic [31:0] pick_operand();
        logic [31:0] val;
        case ($urandom_range(7))
            0:       val = 32'h0000_0000;
            1:       val = 32'hFFFF_FFFF;
            2:       val = 32'h1 << $urandom_range(31);
            3:       val = ~(32'h1 << $urandom_range(31));
            default: val = $urandom();
        endcase
        return val;
    endfunction

    // mostly byte/word/long, now and then the spare size code
    function automatic logic [1:0] pick_size();
        logic [1:0] sz;
        if ($urandom_range(9) == 0)
            sz = SIZE_SPARE;
        else
            sz = 2'($urandom_range(2));
        return sz;
    endfunction

    // short counts keep the run quick; a few go all the way to 63
    function automatic logic [5:0] pick_count();
        logic [5:0] cnt;
        if ($urandom_range(9) == 0)
            cnt = 6'($urandom_range(63));
        else
            cnt = 6'($urandom_range(10));
        return cnt;
    endfunction

    // one input transaction: optional idle gap, then hold valid until the block takes it.
    // called and returning at a falling edge, so valid is touched once per time step
    task automatic send_item(input alu_op_t op, input logic [1:0] sz, input logic [31:0] src,
                             input logic [31:0] tgt, input logic [5:0] cnt);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        action = op;
        size = sz;
        source = src;
        target = tgt;
        shift_count = cnt;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int      phase;
        int      sent;
        int      chain;
        int      waited;
        alu_op_t chain_op;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = 4'd0;
        size = 2'd0;
        source = '0;
        target = '0;
        shift_count = '0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, back to back: carries, borrows, overflow, zero chains through the
        // extend forms, all logic ops, zero and maximum shift counts, rotate through x at
        // count zero, bits above the size and the spare size code
        send_item(OP_ADD,  SIZE_BYTE,  32'h0000_00FF, 32'h0000_0001, 6'd0);
        send_item(OP_ADDX, SIZE_BYTE,  32'h0000_0000, 32'h0000_00FF, 6'd0);
        send_item(OP_ADDX, SIZE_BYTE,  32'h0000_0000, 32'h0000_0000, 6'd0);
        send_item(OP_ADD,  SIZE_LONG,  32'hFFFF_FFFF, 32'h0000_0001, 6'd0);
        send_item(OP_ADDX, SIZE_LONG,  32'h0000_0000, 32'h7FFF_FFFF, 6'd0);
        send_item(OP_SUB,  SIZE_BYTE,  32'h0000_0001, 32'h0000_0080, 6'd0);
        send_item(OP_SUB,  SIZE_WORD,  32'h0000_0001, 32'h0000_0000, 6'd0);
        send_item(OP_SUBX, SIZE_WORD,  32'h0000_FFFF, 32'h0000_FFFF, 6'd0);
        send_item(OP_CMP,  SIZE_LONG,  32'h0000_0001, 32'h0000_0000, 6'd0);
        send_item(OP_AND,  SIZE_WORD,  32'hFFFF_0F0F, 32'h1234_5678, 6'd0);
        send_item(OP_OR,   SIZE_BYTE,  32'hFFFF_FF00, 32'hABCD_EF00, 6'd0);
        send_item(OP_EOR,  SIZE_LONG,  32'hFFFF_FFFF, 32'hAAAA_AAAA, 6'd0);
        send_item(OP_ASL,  SIZE_BYTE,  32'h0000_0000, 32'h0000_0040, 6'd1);
        send_item(OP_ASL,  SIZE_LONG,  32'h0000_0000, 32'h0000_0001, 6'd63);
        send_item(OP_ASR,  SIZE_WORD,  32'h0000_0000, 32'h0000_8000, 6'd63);
        send_item(OP_LSL,  SIZE_BYTE,  32'h0000_0000, 32'h0000_0081, 6'd0);
        send_item(OP_LSR,  SIZE_LONG,  32'h0000_0000, 32'hFFFF_FFFF, 6'd32);
        send_item(OP_ROL,  SIZE_WORD,  32'h0000_0000, 32'h0000_8001, 6'd17);
        send_item(OP_ROR,  SIZE_BYTE,  32'h0000_0000, 32'h0000_0001, 6'd0);
        send_item(OP_ROXL, SIZE_LONG,  32'h0000_0000, 32'h8000_0000, 6'd0);
        send_item(OP_ROXR, SIZE_BYTE,  32'h0000_0000, 32'h0000_0081, 6'd9);
        send_item(OP_ROXL, SIZE_WORD,  32'h0000_0000, 32'h0000_C003, 6'd63);
        send_item(OP_ADD,  SIZE_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        send_item(OP_LSR,  SIZE_SPARE, 32'h0000_0000, 32'h8000_0001, 6'd5);

        // random part in four idling phases: none, sender gaps, receiver stalls, both light
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 85;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 85;
                end
                default:
                begin
                    idle_pct = 19;
                    stall_pct = 19;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(3) == 0)
                begin
                    // multi-precision style chain: a plain add/sub then extend forms,
                    // so x and z carry across transactions
                    chain_op = $urandom_range(1) ? OP_ADDX : OP_SUBX;
                    send_item((chain_op == OP_ADDX) ? OP_ADD : OP_SUB, pick_size(),
                              pick_operand(), pick_operand(), pick_count());
                    sent++;
                    for (chain = $urandom_range(4, 2); chain > 0; chain--)
                    begin
                        send_item(chain_op, pick_size(), pick_operand(), pick_operand(),
                                  pick_count());
                        sent++;
                    end
                end
                else
                begin
                    send_item(alu_op_t'($urandom_range(15)), pick_size(), pick_operand(),
                              pick_operand(), pick_count());
                    sent++;
                end
            end
        end
        in_valid = 1'b0;

        // drain: let the receiver run free, wait for the last results with a bound
        idle_pct = 0;
        stall_pct = 0;
        waited = 0;
        while (outstanding != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (80) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: cpu_alu_shift_flags_top.f
rtl/casf_pkg.sv
rtl/casf_dp.sv
rtl/cpu_alu_shift_flags_top.sv
test/alu_flag_checker.sv
test/cpu_alu_shift_flags_top_tb.sv
